// ===== design/feedback_delay_network_reverb_core_macros.svh =====
// ----------------------------------------------------------------------------
// Reverb core assertion macros
// Clocked, reset-gated assertion helpers used by the reverb core back end.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_DELAY_NETWORK_REVERB_CORE_MACROS_SVH
`define FEEDBACK_DELAY_NETWORK_REVERB_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FDNR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define FDNR_NEVER(lbl, cond, msg) \
   `FDNR_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/fdnr_pkg.sv =====
// ----------------------------------------------------------------------------
// Reverb core package
// Sizes, coefficient tables, shared types and saturation helpers.
// ----------------------------------------------------------------------------
package fdnr_pkg;

   localparam int NUM_PATHS   = 7;
   localparam int MAX_PATHS   = 7;
   localparam int LINE_DEPTH  = 4096;
   localparam int LINE_WIDTH  = 24;

   localparam int SAMPLE_W    = 16;
   localparam int GSCALE_W    = 15;
   localparam int DSCALE_W    = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_SCALE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_SCALE = 2'd1;

   localparam logic [GSCALE_W-1:0] GAIN_SCALE_RESET  = 15'd16384;
   localparam logic [DSCALE_W-1:0] DELAY_SCALE_RESET = 16'd4096;

   localparam int ADDR_W      = $clog2(LINE_DEPTH);
   localparam int DLY_W       = $clog2(LINE_DEPTH + 1);
   localparam int RD_W        = DLY_W + 1;

   // Delay = (len * delay_scale + 2^11) >> 12
   localparam int LEN_W       = 11;
   localparam int DLY_FRAC    = 12;
   localparam int DPROD_W     = LEN_W + DSCALE_W + 1;
   localparam int DRAW_W      = DPROD_W - DLY_FRAC;

   // Gain = (base * gain_scale + 2^13) >> 14
   localparam int GBASE_W     = 15;
   localparam int GAIN_FRAC   = 14;
   localparam int GPROD_W     = GBASE_W + GSCALE_W + 1;
   localparam int EFF_GAIN_W  = GPROD_W - GAIN_FRAC;

   // Tap = (line * gain + 2^14) >>> 15
   localparam int TAP_FRAC    = 15;
   localparam int PROD_W      = LINE_WIDTH + EFF_GAIN_W + 1;
   localparam int TAP_W       = PROD_W - TAP_FRAC;
   localparam int ACC_W       = TAP_W + 3;

   // Back-end stages between line read and line write.
   localparam int PIPE_DEPTH  = 4;
   localparam int OCC_W       = $clog2(PIPE_DEPTH + 1);
   localparam int NEAR_W      = $clog2(PIPE_DEPTH + 2);

   localparam int FIFO_DEPTH  = 8;
   localparam int PTR_W       = $clog2(FIFO_DEPTH);
   localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

   localparam int MIX_HALF    = (NUM_PATHS + 1) / 2;

   localparam logic [LEN_W-1:0] BASE_LEN [MAX_PATHS] =
      '{11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557};

   localparam logic [GBASE_W-1:0] BASE_GAIN [MAX_PATHS] =
      '{15'd24697, 15'd6974, 15'd7014, 15'd19419, 15'd5420, 15'd23076, 15'd3789};

   localparam logic signed [1:0] MIX_P = 2'sb01;
   localparam logic signed [1:0] MIX_N = 2'sb11;
   localparam logic signed [1:0] MIX_Z = 2'sb00;

   localparam logic signed [1:0] MIX_TAB [MAX_PATHS][MAX_PATHS] = '{
      '{MIX_Z, MIX_N, MIX_N, MIX_P, MIX_N, MIX_P, MIX_P},
      '{MIX_P, MIX_Z, MIX_N, MIX_N, MIX_P, MIX_N, MIX_P},
      '{MIX_P, MIX_P, MIX_Z, MIX_N, MIX_N, MIX_P, MIX_N},
      '{MIX_N, MIX_P, MIX_P, MIX_Z, MIX_N, MIX_N, MIX_P},
      '{MIX_P, MIX_N, MIX_P, MIX_P, MIX_Z, MIX_N, MIX_N},
      '{MIX_N, MIX_P, MIX_N, MIX_P, MIX_P, MIX_Z, MIX_N},
      '{MIX_N, MIX_N, MIX_P, MIX_N, MIX_P, MIX_P, MIX_Z}
   };

   localparam logic signed [ACC_W-1:0] LINE_MAX_ACC =
      {{(ACC_W-LINE_WIDTH+1){1'b0}}, {(LINE_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] LINE_MIN_ACC =
      {{(ACC_W-LINE_WIDTH+1){1'b1}}, {(LINE_WIDTH-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] SAMPLE_MAX_ACC =
      {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAMPLE_MIN_ACC =
      {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

   typedef struct packed {
      logic [NUM_PATHS-1:0][DLY_W-1:0]      delay;
      logic [NUM_PATHS-1:0][EFF_GAIN_W-1:0] gain;
      logic [NEAR_W-1:0]                    near;
   } fdnr_cfg_type;

   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
   } fdnr_feed_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } fdnr_ctrl_type;

   function automatic logic signed [LINE_WIDTH-1:0] sat_line(
      input logic signed [ACC_W-1:0] v);
      logic signed [LINE_WIDTH-1:0] r;
      if (v > LINE_MAX_ACC) begin
         r = LINE_WIDTH'(LINE_MAX_ACC);
      end else if (v < LINE_MIN_ACC) begin
         r = LINE_WIDTH'(LINE_MIN_ACC);
      end else begin
         r = LINE_WIDTH'(v);
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > SAMPLE_MAX_ACC) begin
         r = SAMPLE_W'(SAMPLE_MAX_ACC);
      end else if (v < SAMPLE_MIN_ACC) begin
         r = SAMPLE_W'(SAMPLE_MIN_ACC);
      end else begin
         r = SAMPLE_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== design/fdnr_fifo.sv =====
// ----------------------------------------------------------------------------
// Reverb sample queue
// Small register FIFO of signed samples with occupancy count.
// ----------------------------------------------------------------------------
module fdnr_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic signed [fdnr_pkg::SAMPLE_W-1:0] push_data,
   input  logic                                pop,
   output logic signed [fdnr_pkg::SAMPLE_W-1:0] pop_data,
   output logic                                empty,
   output logic                                full,
   output logic [fdnr_pkg::CNT_W-1:0]          count
);

   logic signed [fdnr_pkg::SAMPLE_W-1:0] data_ff [fdnr_pkg::FIFO_DEPTH];
   logic [fdnr_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fdnr_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fdnr_pkg::CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == fdnr_pkg::CNT_W'(fdnr_pkg::FIFO_DEPTH));
   assign count    = count_ff;
   assign pop_data = data_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == fdnr_pkg::PTR_W'(fdnr_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == fdnr_pkg::PTR_W'(fdnr_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/fdnr_front.sv =====
// ----------------------------------------------------------------------------
// Reverb front end
// Control registers, per-path delay and gain derivation, and input queue.
// ----------------------------------------------------------------------------
module fdnr_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [fdnr_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic                                  csr_write_enable,
   input  logic [fdnr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fdnr_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  fdnr_pkg::fdnr_ctrl_type               ctrl,
   output fdnr_pkg::fdnr_cfg_type                cfg,
   output fdnr_pkg::fdnr_feed_type               feed
);

   logic [fdnr_pkg::GSCALE_W-1:0] gain_scale_ff;
   logic [fdnr_pkg::DSCALE_W-1:0] delay_scale_ff;

   logic [fdnr_pkg::NUM_PATHS-1:0][fdnr_pkg::DLY_W-1:0]      delay_ff, delay_in;
   logic [fdnr_pkg::NUM_PATHS-1:0][fdnr_pkg::EFF_GAIN_W-1:0] gain_ff, gain_in;
   logic [fdnr_pkg::NEAR_W-1:0]                              near_ff, near_in;

   logic [fdnr_pkg::DPROD_W-1:0] dprod [fdnr_pkg::NUM_PATHS];
   logic [fdnr_pkg::DRAW_W-1:0]  draw  [fdnr_pkg::NUM_PATHS];
   logic [fdnr_pkg::GPROD_W-1:0] gprod [fdnr_pkg::NUM_PATHS];

   logic q_push, q_empty, q_full;
   logic [fdnr_pkg::CNT_W-1:0] q_count;
   logic signed [fdnr_pkg::SAMPLE_W-1:0] q_data;

   // Control register writes; unknown indexes drop.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_scale_ff  <= fdnr_pkg::GAIN_SCALE_RESET;
         delay_scale_ff <= fdnr_pkg::DELAY_SCALE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            fdnr_pkg::CSR_GAIN_SCALE: begin
               gain_scale_ff <= csr_write_data[fdnr_pkg::GSCALE_W-1:0];
            end
            fdnr_pkg::CSR_DELAY_SCALE: begin
               delay_scale_ff <= csr_write_data[fdnr_pkg::DSCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Derive per-path delay (clamped to the line depth) and effective gain.
   always_comb begin
      for (int i = 0; i < fdnr_pkg::NUM_PATHS; i++) begin
         dprod[i] = fdnr_pkg::DPROD_W'(fdnr_pkg::BASE_LEN[i]) *
                    fdnr_pkg::DPROD_W'(delay_scale_ff) +
                    fdnr_pkg::DPROD_W'(2 ** (fdnr_pkg::DLY_FRAC - 1));
         draw[i]  = dprod[i][fdnr_pkg::DPROD_W-1:fdnr_pkg::DLY_FRAC];
         if (32'(draw[i]) > 32'(fdnr_pkg::LINE_DEPTH)) begin
            delay_in[i] = fdnr_pkg::DLY_W'(fdnr_pkg::LINE_DEPTH);
         end else begin
            delay_in[i] = fdnr_pkg::DLY_W'(draw[i]);
         end
         gprod[i] = fdnr_pkg::GPROD_W'(fdnr_pkg::BASE_GAIN[i]) *
                    fdnr_pkg::GPROD_W'(gain_scale_ff) +
                    fdnr_pkg::GPROD_W'(2 ** (fdnr_pkg::GAIN_FRAC - 1));
         gain_in[i] = gprod[i][fdnr_pkg::GPROD_W-1:fdnr_pkg::GAIN_FRAC];
      end
   end

   // Shortest delay that lands inside the back-end pipeline, else one past it.
   always_comb begin
      near_in = fdnr_pkg::NEAR_W'(fdnr_pkg::PIPE_DEPTH + 1);
      for (int i = 0; i < fdnr_pkg::NUM_PATHS; i++) begin
         if (delay_in[i] != '0 && 32'(delay_in[i]) <= fdnr_pkg::PIPE_DEPTH &&
             fdnr_pkg::NEAR_W'(delay_in[i]) < near_in) begin
            near_in = fdnr_pkg::NEAR_W'(delay_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      delay_ff <= delay_in;
      gain_ff  <= gain_in;
      near_ff  <= near_in;
   end

   assign cfg.delay = delay_ff;
   assign cfg.gain  = gain_ff;
   assign cfg.near  = near_ff;

   // Hold off requests while the lines clear or the queue is full.
   assign req_stall = q_full || ctrl.clearing;
   assign q_push    = req_valid && !req_stall;

   fdnr_fifo u_in_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (req_sample_in),
      .pop       (ctrl.pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .full      (q_full),
      .count     (q_count)
   );

   assign feed.valid  = !q_empty && (q_count != '0);
   assign feed.sample = q_data;

endmodule

// ===== design/fdnr_back.sv =====
// ----------------------------------------------------------------------------
// Reverb back end
// Delay line memories, tap and mix pipeline, clearing pass and result queue.
// ----------------------------------------------------------------------------
`include "feedback_delay_network_reverb_core_macros.svh"

module fdnr_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fdnr_pkg::fdnr_cfg_type                cfg,
   input  fdnr_pkg::fdnr_feed_type               feed,
   output fdnr_pkg::fdnr_ctrl_type               ctrl,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fdnr_pkg::SAMPLE_W-1:0]  rsp_sample_out
);

   logic [fdnr_pkg::LINE_WIDTH-1:0]
      line_mem [fdnr_pkg::NUM_PATHS][fdnr_pkg::LINE_DEPTH];

   logic                        clear_ff, clear_in;
   logic [fdnr_pkg::ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [fdnr_pkg::ADDR_W-1:0] w_ff, w_in;

   logic [fdnr_pkg::OCC_W-1:0]  occ;
   logic hazard, credit, issue;

   logic [fdnr_pkg::RD_W-1:0]   rd_lift [fdnr_pkg::NUM_PATHS];
   logic [fdnr_pkg::ADDR_W-1:0] rd_addr [fdnr_pkg::NUM_PATHS];

   logic                        wr_en;
   logic [fdnr_pkg::ADDR_W-1:0] wr_addr;
   logic signed [fdnr_pkg::LINE_WIDTH-1:0] wr_data [fdnr_pkg::NUM_PATHS];

   // Stage 1: line data
   logic                                 s1_v_ff;
   logic signed [fdnr_pkg::SAMPLE_W-1:0] s1_x_ff;
   logic [fdnr_pkg::ADDR_W-1:0]          s1_w_ff;
   logic signed [fdnr_pkg::LINE_WIDTH-1:0] rd_data_ff [fdnr_pkg::NUM_PATHS];
   // Stage 2: products
   logic                                 s2_v_ff;
   logic signed [fdnr_pkg::SAMPLE_W-1:0] s2_x_ff;
   logic [fdnr_pkg::ADDR_W-1:0]          s2_w_ff;
   logic signed [fdnr_pkg::PROD_W-1:0]   prod_in [fdnr_pkg::NUM_PATHS];
   logic signed [fdnr_pkg::PROD_W-1:0]   prod_ff [fdnr_pkg::NUM_PATHS];
   // Stage 3: rounded taps
   logic                                 s3_v_ff;
   logic signed [fdnr_pkg::SAMPLE_W-1:0] s3_x_ff;
   logic [fdnr_pkg::ADDR_W-1:0]          s3_w_ff;
   logic signed [fdnr_pkg::PROD_W-1:0]   tap_round [fdnr_pkg::NUM_PATHS];
   logic signed [fdnr_pkg::TAP_W-1:0]    taps_ff [fdnr_pkg::NUM_PATHS];
   // Stage 4: partial mixes and sums
   logic                                 s4_v_ff;
   logic [fdnr_pkg::ADDR_W-1:0]          s4_w_ff;
   logic signed [fdnr_pkg::ACC_W-1:0]    mix_a_in [fdnr_pkg::NUM_PATHS];
   logic signed [fdnr_pkg::ACC_W-1:0]    mix_b_in [fdnr_pkg::NUM_PATHS];
   logic signed [fdnr_pkg::ACC_W-1:0]    mix_a_ff [fdnr_pkg::NUM_PATHS];
   logic signed [fdnr_pkg::ACC_W-1:0]    mix_b_ff [fdnr_pkg::NUM_PATHS];
   logic signed [fdnr_pkg::ACC_W-1:0]    sum_a_in, sum_b_in, sum_a_ff, sum_b_ff;
   logic signed [fdnr_pkg::ACC_W-1:0]    mix_full [fdnr_pkg::NUM_PATHS];
   logic signed [fdnr_pkg::ACC_W-1:0]    sum_full;

   logic out_empty, out_full, out_pop;
   logic [fdnr_pkg::CNT_W-1:0] out_count;
   logic signed [fdnr_pkg::SAMPLE_W-1:0] out_data;

   // Clearing pass: one row of all lines per cycle after reset.
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         if (clr_addr_ff == fdnr_pkg::ADDR_W'(fdnr_pkg::LINE_DEPTH - 1)) begin
            clear_in    = 1'b0;
            clr_addr_in = '0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   // In-flight items hold the most recent write indexes w-1 .. w-occ.
   assign occ = fdnr_pkg::OCC_W'(s1_v_ff) + fdnr_pkg::OCC_W'(s2_v_ff) +
                fdnr_pkg::OCC_W'(s3_v_ff) + fdnr_pkg::OCC_W'(s4_v_ff);
   assign hazard = (32'(cfg.near) <= 32'(occ));
   assign credit = (32'(out_count) + 32'(occ) < fdnr_pkg::FIFO_DEPTH);
   assign issue  = feed.valid && !clear_ff && !hazard && credit;

   assign ctrl.pop      = issue;
   assign ctrl.clearing = clear_ff;

   always_comb begin
      w_in = w_ff;
      if (issue) begin
         w_in = (w_ff == fdnr_pkg::ADDR_W'(fdnr_pkg::LINE_DEPTH - 1)) ?
                '0 : w_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
         w_ff        <= '0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         s4_v_ff     <= 1'b0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
         w_ff        <= w_in;
         s1_v_ff     <= issue;
         s2_v_ff     <= s1_v_ff;
         s3_v_ff     <= s2_v_ff;
         s4_v_ff     <= s3_v_ff;
      end
   end

   // Read index = (w - delay) modulo the line depth.
   always_comb begin
      for (int p = 0; p < fdnr_pkg::NUM_PATHS; p++) begin
         rd_lift[p] = fdnr_pkg::RD_W'(w_ff) + fdnr_pkg::RD_W'(fdnr_pkg::LINE_DEPTH) -
                      fdnr_pkg::RD_W'(cfg.delay[p]);
         if (rd_lift[p] >= fdnr_pkg::RD_W'(fdnr_pkg::LINE_DEPTH)) begin
            rd_addr[p] = fdnr_pkg::ADDR_W'(rd_lift[p] -
                                           fdnr_pkg::RD_W'(fdnr_pkg::LINE_DEPTH));
         end else begin
            rd_addr[p] = fdnr_pkg::ADDR_W'(rd_lift[p]);
         end
      end
   end

   // Final mix, saturation and line write-back.
   always_comb begin
      for (int p = 0; p < fdnr_pkg::NUM_PATHS; p++) begin
         mix_full[p] = mix_a_ff[p] + mix_b_ff[p];
         wr_data[p]  = clear_ff ? '0 : fdnr_pkg::sat_line(mix_full[p]);
      end
      sum_full = sum_a_ff + sum_b_ff;
   end

   assign wr_en   = clear_ff || s4_v_ff;
   assign wr_addr = clear_ff ? clr_addr_ff : s4_w_ff;

   always_ff @(posedge clock) begin
      for (int p = 0; p < fdnr_pkg::NUM_PATHS; p++) begin
         if (wr_en) begin
            line_mem[p][wr_addr] <= wr_data[p];
         end
         rd_data_ff[p] <= line_mem[p][rd_addr[p]];
      end
   end

   // Weight, round and mix.
   always_comb begin
      for (int p = 0; p < fdnr_pkg::NUM_PATHS; p++) begin
         prod_in[p]   = rd_data_ff[p] * $signed({1'b0, cfg.gain[p]});
         tap_round[p] = prod_ff[p] +
                        fdnr_pkg::PROD_W'(2 ** (fdnr_pkg::TAP_FRAC - 1));
      end
   end

   always_comb begin
      sum_a_in = '0;
      sum_b_in = '0;
      for (int i = 0; i < fdnr_pkg::NUM_PATHS; i++) begin
         mix_a_in[i] = fdnr_pkg::ACC_W'(s3_x_ff);
         mix_b_in[i] = '0;
         for (int j = 0; j < fdnr_pkg::NUM_PATHS; j++) begin
            if (j < fdnr_pkg::MIX_HALF) begin
               if (fdnr_pkg::MIX_TAB[i][j] == fdnr_pkg::MIX_P) begin
                  mix_a_in[i] = mix_a_in[i] + fdnr_pkg::ACC_W'(taps_ff[j]);
               end else if (fdnr_pkg::MIX_TAB[i][j] == fdnr_pkg::MIX_N) begin
                  mix_a_in[i] = mix_a_in[i] - fdnr_pkg::ACC_W'(taps_ff[j]);
               end
            end else begin
               if (fdnr_pkg::MIX_TAB[i][j] == fdnr_pkg::MIX_P) begin
                  mix_b_in[i] = mix_b_in[i] + fdnr_pkg::ACC_W'(taps_ff[j]);
               end else if (fdnr_pkg::MIX_TAB[i][j] == fdnr_pkg::MIX_N) begin
                  mix_b_in[i] = mix_b_in[i] - fdnr_pkg::ACC_W'(taps_ff[j]);
               end
            end
         end
         if (i < fdnr_pkg::MIX_HALF) begin
            sum_a_in = sum_a_in + fdnr_pkg::ACC_W'(taps_ff[i]);
         end else begin
            sum_b_in = sum_b_in + fdnr_pkg::ACC_W'(taps_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_x_ff <= feed.sample;
      s1_w_ff <= w_ff;
      s2_x_ff <= s1_x_ff;
      s2_w_ff <= s1_w_ff;
      s3_x_ff <= s2_x_ff;
      s3_w_ff <= s2_w_ff;
      s4_w_ff <= s3_w_ff;
      for (int p = 0; p < fdnr_pkg::NUM_PATHS; p++) begin
         prod_ff[p]  <= prod_in[p];
         taps_ff[p]  <= fdnr_pkg::TAP_W'(tap_round[p] >>> fdnr_pkg::TAP_FRAC);
         mix_a_ff[p] <= mix_a_in[p];
         mix_b_ff[p] <= mix_b_in[p];
      end
      sum_a_ff <= sum_a_in;
      sum_b_ff <= sum_b_in;
   end

   // Result queue decouples the pipeline from the consumer.
   assign out_pop = rsp_valid && !rsp_stall;

   fdnr_fifo u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s4_v_ff),
      .push_data (fdnr_pkg::sat_sample(sum_full)),
      .pop       (out_pop),
      .pop_data  (out_data),
      .empty     (out_empty),
      .full      (out_full),
      .count     (out_count)
   );

   assign rsp_valid      = !out_empty;
   assign rsp_sample_out = out_data;

   `FDNR_NEVER(a_issue_in_clear, issue && clear_ff, "request issued during line clear")
   `FDNR_NEVER(a_out_overflow, s4_v_ff && out_full, "result queue overflow")
   `FDNR_ASSERT(a_wr_index_track, s4_v_ff |-> (s4_w_ff == $past(w_ff, 4)), "write index slip")

endmodule

// ===== design/feedback_delay_network_reverb_core.sv =====
// ----------------------------------------------------------------------------
// Feedback delay network reverb core
// Reset: lines clear one row per cycle, with req_stall held high.
// Throughput: one request per cycle unless held by the clearing pass, a result
// queue with no room for the request, or a path delay of 1..4 samples, which holds
// issue until the older sample's line write lands (the 4-stage read-to-write loop).
// ----------------------------------------------------------------------------
//
// Structure:
//   fdnr_front  - control registers, derives registered per-path delay and gain
//                 from them, and queues incoming requests.
//   fdnr_back   - seven delay line memories sharing one write index, a
//                 four-stage pipeline (read, weight, round, mix) with the
//                 line write-back in the last stage, and a result queue.
//
// The back end issues a request from the input queue when:
//   - the clearing pass is done,
//   - the result queue has room for everything already in flight and this request,
//   - no in-flight request still owes a line entry that this one reads.
// Requests in flight always hold the newest write indexes, so the read-after-
// write check reduces to comparing the shortest in-pipe delay with the count
// of requests in flight.
//
// Configuration writes land any time; the derived delay and gain tables are
// registered from the scale registers. Writes are expected only while the core is idle.
module feedback_delay_network_reverb_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [fdnr_pkg::SAMPLE_W-1:0]  req_sample_in,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fdnr_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   // control register write port
   input  logic                                  csr_write_enable,
   input  logic [fdnr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fdnr_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   fdnr_pkg::fdnr_cfg_type  cfg;
   fdnr_pkg::fdnr_feed_type feed;
   fdnr_pkg::fdnr_ctrl_type ctrl;

   // Accept and queue requests, hold configuration.
   fdnr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .ctrl             (ctrl),
      .cfg              (cfg),
      .feed             (feed)
   );

   // Run the delay network and deliver results.
   fdnr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .feed           (feed),
      .ctrl           (ctrl),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule
